>>> rtl/core/cnrp_pkg.sv
// Package for the complex Newton root polisher.
// Holds field widths, register indexes, outcome codes and saturation helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cnrp_pkg;

    localparam int MAX_DEGREE_DEF = 8;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int VAL_W   = 32;
    localparam int IDX_W   = 4;
    localparam int DEG_W   = 4;
    localparam int ITER_W  = 6;
    localparam int TOL_W   = 31;
    localparam int OUTC_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd2;

    // Function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_REFINE = 1'b1;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUT_CONVERGED = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_NO_IMPROVE = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_ZERO_DERIV = 2'd2;
    localparam logic [OUTC_W-1:0] OUT_ITER_LIMIT = 2'd3;

    // Saturate a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -65'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Lift the most negative value by one so that negation stays in range
    function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v == 32'sh80000000)
            r = 32'sh80000001;
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/cnrp_if.sv
// Valid/ready channel interfaces for the root polisher request and result streams.
// Depends on cnrp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cnrp_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic [cnrp_pkg::IDX_W-1:0]           coef_index;
    logic signed [cnrp_pkg::VAL_W-1:0]    coef_value;
    logic signed [cnrp_pkg::VAL_W-1:0]    start_re;
    logic signed [cnrp_pkg::VAL_W-1:0]    start_im;

    modport source (output valid, func, coef_index, coef_value, start_re, start_im,
                    input ready);
    modport sink   (input valid, func, coef_index, coef_value, start_re, start_im,
                    output ready);
endinterface

interface cnrp_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cnrp_pkg::VAL_W-1:0]    root_re;
    logic signed [cnrp_pkg::VAL_W-1:0]    root_im;
    logic [cnrp_pkg::OUTC_W-1:0]          outcome;
    logic [cnrp_pkg::ITER_W-1:0]          iterations;

    modport source (output valid, root_re, root_im, outcome, iterations, input ready);
    modport sink   (input valid, root_re, root_im, outcome, iterations, output ready);
endinterface

`default_nettype wire

>>> rtl/core/complex_newton_root_polish_core.sv
// A load writes one coefficient to the RAM. A refine evaluates the start residual,
// then runs Newton steps up to the iteration limit and finishes. One 32x32
// multiplier and a radix-2 divider are shared under one sequencer.
// Throughput: one item at a time; ready is high only while the sequencer is idle.
// Reset: async active low; degree 1, iter_limit 10, tolerance 66; coefficient RAM kept.
`timescale 1ns / 1ps
`default_nettype none

module complex_newton_root_polish_core #(
    parameter int MAX_DEGREE = cnrp_pkg::MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = cnrp_pkg::FRAC_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire [cnrp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [cnrp_pkg::CFG_DATA_W-1:0]    cfg_data,
    cnrp_req_if.sink                          req,
    cnrp_rsp_if.source                        rsp
);

    localparam int KW = $clog2(MAX_DEGREE + 1);
    localparam int QW = 33;
    localparam int CW = $clog2(QW + 1);
    localparam int DW = 64 + FRAC_BITS;

    localparam logic [1:0] PH_P0 = 2'd0;
    localparam logic [1:0] PH_D  = 2'd1;
    localparam logic [1:0] PH_PN = 2'd2;

    localparam logic [QW-1:0] Q_CAP = QW'(64'h8000_0000);

    typedef enum logic [30:0] {
        S_IDLE = 31'd1 << 0,
        S_TOL  = 31'd1 << 1,
        S_EVI  = 31'd1 << 2,
        S_RD   = 31'd1 << 3,
        S_CF   = 31'd1 << 4,
        S_KC   = 31'd1 << 5,
        S_M0   = 31'd1 << 6,
        S_M1   = 31'd1 << 7,
        S_M2   = 31'd1 << 8,
        S_M3   = 31'd1 << 9,
        S_M4   = 31'd1 << 10,
        S_M5   = 31'd1 << 11,
        S_M6   = 31'd1 << 12,
        S_RET  = 31'd1 << 13,
        S_NRM0 = 31'd1 << 14,
        S_NRM1 = 31'd1 << 15,
        S_NRM2 = 31'd1 << 16,
        S_CMP  = 31'd1 << 17,
        S_ITER = 31'd1 << 18,
        S_DV0  = 31'd1 << 19,
        S_DV1  = 31'd1 << 20,
        S_DV2  = 31'd1 << 21,
        S_DV3  = 31'd1 << 22,
        S_DV4  = 31'd1 << 23,
        S_DIVI = 31'd1 << 24,
        S_DIVR = 31'd1 << 25,
        S_DIVF = 31'd1 << 26,
        S_DV5  = 31'd1 << 27,
        S_DV6  = 31'd1 << 28,
        S_DV7  = 31'd1 << 29,
        S_FIN  = 31'd1 << 30
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [cnrp_pkg::DEG_W-1:0]  degree_reg;
    logic [cnrp_pkg::ITER_W-1:0] iter_lim_reg;
    logic [cnrp_pkg::TOL_W-1:0]  tol_reg;

    // Sequencer control
    logic [1:0]                  phase_reg;
    logic [KW-1:0]               k_reg;
    logic [KW-1:0]               deg_eff_reg;
    logic [cnrp_pkg::ITER_W-1:0] it_reg;
    logic [cnrp_pkg::ITER_W-1:0] steps_reg;
    logic [cnrp_pkg::OUTC_W-1:0] outcome_reg;
    logic                        div_sel_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        out_valid_reg;

    // Datapath registers
    logic signed [31:0] last_re_reg, last_im_reg;
    logic signed [31:0] lv_re_reg, lv_im_reg;
    logic signed [31:0] nz_re_reg, nz_im_reg;
    logic signed [31:0] z_re_reg, z_im_reg;
    logic signed [31:0] acc_re_reg, acc_im_reg;
    logic signed [31:0] pw_re_reg, pw_im_reg;
    logic signed [31:0] c_reg, tmp_re_reg;
    logic signed [64:0] t_reg;
    logic signed [63:0] p_reg;
    logic [63:0]        last_sq_reg, nsq_reg, tol_sq_reg, den_reg;
    logic signed [63:0] num_reg;
    logic [63:0]        rem_reg;
    logic [QW-1:0]      dsh_reg;
    logic [QW-1:0]      q_reg;
    logic               neg_reg;
    logic signed [31:0] out_re_reg, out_im_reg;
    logic [cnrp_pkg::OUTC_W-1:0] out_outc_reg;
    logic [cnrp_pkg::ITER_W-1:0] out_iter_reg;

    // Shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] p_next;
    logic signed [64:0] p_fsh;

    // Coefficient RAM
    logic [31:0] ram_rdata;
    logic        ram_we;

    // Clamped operands of the complex division
    logic signed [31:0] ca, cb, cc, ce;

    // Divider helpers
    logic [63:0]        mag;
    logic [DW-1:0]      dvd;
    logic [64:0]        rem2;
    logic [QW-1:0]      qc;
    logic signed [32:0] qs;
    logic signed [31:0] new_coord;

    logic req_xfer, rsp_xfer;
    logic out_load;

    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign rsp_xfer  = rsp.valid && rsp.ready;

    // Result register takes a new result when empty or draining this cycle
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    assign rsp.valid      = out_valid_reg;
    assign rsp.root_re    = out_re_reg;
    assign rsp.root_im    = out_im_reg;
    assign rsp.outcome    = out_outc_reg;
    assign rsp.iterations = out_iter_reg;

    assign ram_we = req_xfer && (req.func == cnrp_pkg::FUNC_LOAD)
                    && (32'(req.coef_index) <= MAX_DEGREE);

    cnrp_ram #(
        .WIDTH (32),
        .DEPTH (MAX_DEGREE + 1)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (KW'(req.coef_index)),
        .wdata (req.coef_value),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    assign ca = cnrp_pkg::clamp_sym(lv_re_reg);
    assign cb = cnrp_pkg::clamp_sym(lv_im_reg);
    assign cc = cnrp_pkg::clamp_sym(acc_re_reg);
    assign ce = cnrp_pkg::clamp_sym(acc_im_reg);

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TOL:
            begin
                mul_a = $signed({1'b0, tol_reg});
                mul_b = $signed({1'b0, tol_reg});
            end
            S_CF:
            begin
                mul_a = $signed(32'(k_reg));
                mul_b = $signed(ram_rdata);
            end
            S_M0:   begin mul_a = c_reg;      mul_b = pw_re_reg;  end
            S_M1:   begin mul_a = c_reg;      mul_b = pw_im_reg;  end
            S_M2:   begin mul_a = z_re_reg;   mul_b = pw_re_reg;  end
            S_M3:   begin mul_a = z_im_reg;   mul_b = pw_im_reg;  end
            S_M4:   begin mul_a = z_re_reg;   mul_b = pw_im_reg;  end
            S_M5:   begin mul_a = z_im_reg;   mul_b = pw_re_reg;  end
            S_NRM0: begin mul_a = acc_re_reg; mul_b = acc_re_reg; end
            S_NRM1: begin mul_a = acc_im_reg; mul_b = acc_im_reg; end
            S_DV0:  begin mul_a = cc;         mul_b = cc;         end
            S_DV1:  begin mul_a = ce;         mul_b = ce;         end
            S_DV2:  begin mul_a = ca;         mul_b = cc;         end
            S_DV3:  begin mul_a = cb;         mul_b = ce;         end
            S_DV5:  begin mul_a = cb;         mul_b = cc;         end
            S_DV6:  begin mul_a = ca;         mul_b = ce;         end
            default: begin mul_a = '0;        mul_b = '0;         end
        endcase
    end

    assign p_next = mul_a * mul_b;
    assign p_fsh  = 65'(p_reg) >>> FRAC_BITS;

    // Divider arithmetic
    assign mag  = (num_reg < 0) ? 64'(-num_reg) : 64'(num_reg);
    assign dvd  = {mag, {FRAC_BITS{1'b0}}};
    assign rem2 = {rem_reg, dsh_reg[QW-1]};
    assign qc   = (q_reg > Q_CAP) ? Q_CAP : q_reg;
    assign qs   = neg_reg ? $signed(33'(~qc + 33'd1))
                          : ((qc == Q_CAP) ? $signed(Q_CAP - 33'd1) : $signed(qc));
    assign new_coord = cnrp_pkg::sat32(
        (div_sel_reg ? 65'(last_im_reg) : 65'(last_re_reg)) - 65'(qs));

    // Product register
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg   <= cnrp_pkg::DEG_W'(1);
            iter_lim_reg <= cnrp_pkg::ITER_W'(10);
            tol_reg      <= cnrp_pkg::TOL_W'(66);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cnrp_pkg::REG_DEGREE:     degree_reg   <= cfg_data[cnrp_pkg::DEG_W-1:0];
                cnrp_pkg::REG_ITER_LIMIT: iter_lim_reg <= cfg_data[cnrp_pkg::ITER_W-1:0];
                cnrp_pkg::REG_TOLERANCE:  tol_reg      <= cfg_data[cnrp_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_P0;
            k_reg         <= '0;
            deg_eff_reg   <= '0;
            it_reg        <= '0;
            steps_reg     <= '0;
            outcome_reg   <= cnrp_pkg::OUT_ITER_LIMIT;
            div_sel_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Result valid: set on finish, cleared on transfer
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_xfer)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_xfer && (req.func == cnrp_pkg::FUNC_REFINE))
                    begin
                        if (32'(degree_reg) > MAX_DEGREE)
                            deg_eff_reg <= KW'(MAX_DEGREE);
                        else
                            deg_eff_reg <= KW'(degree_reg);
                        it_reg      <= '0;
                        steps_reg   <= '0;
                        outcome_reg <= cnrp_pkg::OUT_ITER_LIMIT;
                        phase_reg   <= PH_P0;
                        state_reg   <= S_TOL;
                    end
                end
                S_TOL: state_reg <= S_EVI;
                S_EVI:
                begin
                    k_reg <= (phase_reg == PH_D) ? KW'(1) : KW'(0);
                    if ((phase_reg == PH_D) && (deg_eff_reg == '0))
                        state_reg <= S_RET;
                    else
                        state_reg <= S_RD;
                end
                S_RD: state_reg <= S_CF;
                S_CF: state_reg <= (phase_reg == PH_D) ? S_KC : S_M0;
                S_KC: state_reg <= S_M0;
                S_M0: state_reg <= S_M1;
                S_M1: state_reg <= S_M2;
                S_M2: state_reg <= S_M3;
                S_M3: state_reg <= S_M4;
                S_M4: state_reg <= S_M5;
                S_M5: state_reg <= S_M6;
                S_M6:
                begin
                    if (k_reg == deg_eff_reg)
                        state_reg <= S_RET;
                    else
                    begin
                        k_reg     <= k_reg + KW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_RET:
                begin
                    if (phase_reg != PH_D)
                        state_reg <= S_NRM0;
                    else if ((acc_re_reg == 0) && (acc_im_reg == 0))
                    begin
                        outcome_reg <= cnrp_pkg::OUT_ZERO_DERIV;
                        state_reg   <= S_FIN;
                    end
                    else
                        state_reg <= S_DV0;
                end
                S_NRM0: state_reg <= S_NRM1;
                S_NRM1: state_reg <= S_NRM2;
                S_NRM2: state_reg <= S_CMP;
                S_CMP:
                begin
                    if (phase_reg == PH_P0)
                        state_reg <= S_ITER;
                    else if (nsq_reg < tol_sq_reg)
                    begin
                        outcome_reg <= cnrp_pkg::OUT_CONVERGED;
                        state_reg   <= S_FIN;
                    end
                    else if (nsq_reg < last_sq_reg)
                    begin
                        it_reg    <= it_reg + cnrp_pkg::ITER_W'(1);
                        state_reg <= S_ITER;
                    end
                    else
                    begin
                        outcome_reg <= cnrp_pkg::OUT_NO_IMPROVE;
                        state_reg   <= S_FIN;
                    end
                end
                S_ITER:
                begin
                    if (it_reg < iter_lim_reg)
                    begin
                        phase_reg <= PH_D;
                        state_reg <= S_EVI;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_DV0: state_reg <= S_DV1;
                S_DV1: state_reg <= S_DV2;
                S_DV2: state_reg <= S_DV3;
                S_DV3: state_reg <= S_DV4;
                S_DV4:
                begin
                    div_sel_reg <= 1'b0;
                    state_reg   <= S_DIVI;
                end
                S_DIVI:
                begin
                    cnt_reg <= CW'(QW);
                    if (64'(dvd[DW-1:QW]) >= den_reg)
                        state_reg <= S_DIVF;
                    else
                        state_reg <= S_DIVR;
                end
                S_DIVR:
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                        state_reg <= S_DIVF;
                end
                S_DIVF:
                begin
                    if (!div_sel_reg)
                        state_reg <= S_DV5;
                    else
                    begin
                        steps_reg <= it_reg + cnrp_pkg::ITER_W'(1);
                        phase_reg <= PH_PN;
                        state_reg <= S_EVI;
                    end
                end
                S_DV5: state_reg <= S_DV6;
                S_DV6: state_reg <= S_DV7;
                S_DV7:
                begin
                    div_sel_reg <= 1'b1;
                    state_reg   <= S_DIVI;
                end
                S_FIN:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                last_re_reg <= req.start_re;
                last_im_reg <= req.start_im;
            end
            S_EVI:
            begin
                if (phase_reg == PH_P0)
                    tol_sq_reg <= 64'(p_reg);
                acc_re_reg <= '0;
                acc_im_reg <= '0;
                pw_re_reg  <= 32'(33'd1 << FRAC_BITS);
                pw_im_reg  <= '0;
                if (phase_reg == PH_PN)
                begin
                    z_re_reg <= nz_re_reg;
                    z_im_reg <= nz_im_reg;
                end
                else
                begin
                    z_re_reg <= last_re_reg;
                    z_im_reg <= last_im_reg;
                end
            end
            S_CF:
            begin
                c_reg <= $signed(ram_rdata);
            end
            S_KC: c_reg <= cnrp_pkg::sat32(65'(p_reg));
            S_M1: acc_re_reg <= cnrp_pkg::sat32(65'(acc_re_reg) + p_fsh);
            S_M2: acc_im_reg <= cnrp_pkg::sat32(65'(acc_im_reg) + p_fsh);
            S_M3: t_reg <= p_fsh;
            S_M4: tmp_re_reg <= cnrp_pkg::sat32(t_reg - p_fsh);
            S_M5: t_reg <= p_fsh;
            S_M6:
            begin
                pw_im_reg <= cnrp_pkg::sat32(t_reg + p_fsh);
                pw_re_reg <= tmp_re_reg;
            end
            S_NRM1: nsq_reg <= 64'(p_reg);
            S_NRM2: nsq_reg <= nsq_reg + 64'(p_reg);
            S_CMP:
            begin
                if (phase_reg == PH_P0)
                begin
                    last_sq_reg <= nsq_reg;
                    lv_re_reg   <= acc_re_reg;
                    lv_im_reg   <= acc_im_reg;
                end
                else if (nsq_reg < tol_sq_reg)
                begin
                    last_re_reg <= nz_re_reg;
                    last_im_reg <= nz_im_reg;
                end
                else if (nsq_reg < last_sq_reg)
                begin
                    last_re_reg <= nz_re_reg;
                    last_im_reg <= nz_im_reg;
                    lv_re_reg   <= acc_re_reg;
                    lv_im_reg   <= acc_im_reg;
                    last_sq_reg <= nsq_reg;
                end
            end
            S_DV1: den_reg <= 64'(p_reg);
            S_DV2: den_reg <= den_reg + 64'(p_reg);
            S_DV3: num_reg <= p_reg;
            S_DV4: num_reg <= num_reg + p_reg;
            S_DV6: num_reg <= p_reg;
            S_DV7: num_reg <= num_reg - p_reg;
            S_DIVI:
            begin
                neg_reg <= (num_reg < 0);
                rem_reg <= 64'(dvd[DW-1:QW]);
                dsh_reg <= dvd[QW-1:0];
                q_reg   <= '1;
            end
            S_DIVR:
            begin
                dsh_reg <= {dsh_reg[QW-2:0], 1'b0};
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_reg <= 64'(rem2 - {1'b0, den_reg});
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[63:0];
                    q_reg   <= {q_reg[QW-2:0], 1'b0};
                end
            end
            S_DIVF:
            begin
                if (div_sel_reg)
                    nz_im_reg <= new_coord;
                else
                    nz_re_reg <= new_coord;
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    out_re_reg   <= last_re_reg;
                    out_im_reg   <= last_im_reg;
                    out_outc_reg <= outcome_reg;
                    out_iter_reg <= steps_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    // Divider partial remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVR) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    // Coefficient index never runs past the effective degree
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_M6) |-> (k_reg <= deg_eff_reg))
        else $error("coefficient index beyond degree");

    // Step counter bounded by the iteration limit while a refine runs
    a_it_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (it_reg <= iter_lim_reg))
        else $error("iteration count beyond limit");

    // A result appears only out of the finish step
    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result valid raised outside finish");
`endif

endmodule

`default_nettype wire

>>> rtl/core/cnrp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cnrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
